[design/sqe_pkg.sv]
// ----------------------------------------------------------------------------
// sqe_pkg
// Shared constants, codes and controller/datapath types of the stack/queue
// engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sqe_pkg;

  localparam int DEPTH  = 64;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int STS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_SET_STACK = 3'd0,
    OP_SET_QUEUE = 3'd1,
    OP_PUSH      = 3'd2,
    OP_POP       = 3'd3,
    OP_PEEK      = 3'd4,
    OP_DUMP      = 3'd5
  } op_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic            latch;
    logic            set_mode;
    logic            mode_val;
    logic            push;
    logic            pop;
    logic            rd_en;
    logic            rd_first;
    logic            load;
    logic            from_mem;
    status_e         res_status;
    logic            res_last;
  } sqe_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            full;
    logic            walk_last;
    logic            out_free;
  } sqe_sts_t;

endpackage

`default_nettype wire

[design/sqe_if.sv]
// ----------------------------------------------------------------------------
// sqe_in_if / sqe_out_if
// Valid/ready channels of the stack/queue engine: command beats in, result
// beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sqe_in_if;
  logic                                valid;
  logic                                ready;
  logic [sqe_pkg::OP_W-1:0]            operation;
  logic signed [sqe_pkg::DATA_W-1:0]   push_data;

  modport source (output valid, output operation, output push_data, input ready);
  modport sink   (input valid, input operation, input push_data, output ready);
endinterface

interface sqe_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sqe_pkg::DATA_W-1:0]   data;
  logic [sqe_pkg::STS_W-1:0]           status;
  logic                                last;

  modport source (output valid, output data, output status, output last, input ready);
  modport sink   (input valid, input data, input status, input last, output ready);
endinterface

`default_nettype wire

[design/sqe_ctrl.sv]
// ----------------------------------------------------------------------------
// sqe_ctrl
// Command sequencer: accepts one command beat, runs it against the datapath
// and walks the store for peek and dump.
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sqe_pkg::sqe_sts_t sts_i,
  output sqe_pkg::sqe_cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = sqe_pkg::ST_OK;
    cmd_o.res_last   = 1'b1;
    state_d          = state_q;
    in_ready_o       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.op)
          sqe_pkg::OP_SET_STACK, sqe_pkg::OP_SET_QUEUE: begin
            if (sts_i.out_free) begin
              cmd_o.set_mode = 1'b1;
              cmd_o.mode_val = (sts_i.op == sqe_pkg::OP_SET_QUEUE);
              cmd_o.load     = 1'b1;
              state_d        = S_IDLE;
            end
          end
          sqe_pkg::OP_PUSH: begin
            if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = sqe_pkg::ST_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          sqe_pkg::OP_POP: begin
            if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              if (sts_i.empty) begin
                cmd_o.res_status = sqe_pkg::ST_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
              state_d = S_IDLE;
            end
          end
          sqe_pkg::OP_PEEK: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.load       = 1'b1;
                cmd_o.res_status = sqe_pkg::ST_EMPTY;
                state_d          = S_IDLE;
              end
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_first = 1'b1;
              state_d        = S_EMIT;
            end
          end
          sqe_pkg::OP_DUMP: begin
            if (sts_i.empty) begin
              state_d = S_IDLE;
            end else begin
              cmd_o.rd_en    = 1'b1;
              cmd_o.rd_first = 1'b1;
              state_d        = S_EMIT;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_EMIT: begin
        cmd_o.res_last = (sts_i.op == sqe_pkg::OP_PEEK) || sts_i.walk_last;
        if (sts_i.out_free) begin
          cmd_o.load     = 1'b1;
          cmd_o.from_mem = 1'b1;
          if (cmd_o.res_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> !sts_i.empty)
    else $error("walk running on an empty store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && !cmd_o.rd_first) |=> (state_q == S_EMIT))
    else $error("walk advanced without emitting the read entry");

endmodule

`default_nettype wire

[design/sqe_dpath.sv]
// ----------------------------------------------------------------------------
// sqe_dpath
// Entry store, head/count/mode registers, walk pointer and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [sqe_pkg::OP_W-1:0]          operation_i,
  input  wire logic signed [sqe_pkg::DATA_W-1:0] push_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [sqe_pkg::DATA_W-1:0]      out_data_o,
  output logic [sqe_pkg::STS_W-1:0]              out_status_o,
  output logic                                   out_last_o,
  input  wire sqe_pkg::sqe_cmd_t                 cmd_i,
  output sqe_pkg::sqe_sts_t                      sts_o
);

  logic [sqe_pkg::DATA_W-1:0] mem_q [sqe_pkg::DEPTH];

  logic [sqe_pkg::OP_W-1:0]          op_q;
  logic signed [sqe_pkg::DATA_W-1:0] push_data_q;
  logic [sqe_pkg::PTR_W-1:0]         head_q, head_d;
  logic [sqe_pkg::CNT_W-1:0]         count_q, count_d;
  logic                              mode_q;
  logic [sqe_pkg::PTR_W-1:0]         walk_q;
  logic [sqe_pkg::CNT_W-1:0]         k_q;
  logic [sqe_pkg::DATA_W-1:0]        rd_data_q;
  logic                              out_valid_q;
  logic signed [sqe_pkg::DATA_W-1:0] out_data_q;
  logic [sqe_pkg::STS_W-1:0]         out_status_q;
  logic                              out_last_q;

  logic [sqe_pkg::PTR_W-1:0] head_dec, head_inc, walk_inc, tail, wr_addr, rd_addr;
  logic [sqe_pkg::SUM_W-1:0] tail_sum;
  logic                      empty, full, out_free, at_front;

  assign empty    = (count_q == '0);
  assign full     = (count_q == sqe_pkg::CNT_W'(sqe_pkg::DEPTH));
  assign out_free = !out_valid_q || out_ready_i;

  assign head_dec = (head_q == '0) ? sqe_pkg::PTR_W'(sqe_pkg::DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == sqe_pkg::PTR_W'(sqe_pkg::DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign walk_inc = (walk_q == sqe_pkg::PTR_W'(sqe_pkg::DEPTH - 1)) ? '0 : walk_q + 1'b1;

  assign tail_sum = sqe_pkg::SUM_W'(head_q) + sqe_pkg::SUM_W'(count_q);
  assign tail     = (tail_sum >= sqe_pkg::SUM_W'(sqe_pkg::DEPTH))
                  ? sqe_pkg::PTR_W'(tail_sum - sqe_pkg::SUM_W'(sqe_pkg::DEPTH))
                  : sqe_pkg::PTR_W'(tail_sum);

  assign at_front = !mode_q || empty;
  assign wr_addr  = at_front ? head_dec : tail;
  assign rd_addr  = cmd_i.rd_first ? head_q : walk_inc;

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + 1'b1;
      if (at_front) begin
        head_d = head_dec;
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
      head_d  = head_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.set_mode) begin
        mode_q <= cmd_i.mode_val;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q        <= operation_i;
      push_data_q <= push_data_i;
    end
    if (cmd_i.push) begin
      mem_q[wr_addr] <= push_data_q;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
      walk_q    <= rd_addr;
      k_q       <= cmd_i.rd_first ? '0 : k_q + 1'b1;
    end
    if (cmd_i.load) begin
      out_data_q   <= cmd_i.from_mem ? rd_data_q : '0;
      out_status_q <= cmd_i.res_status;
      out_last_q   <= cmd_i.res_last;
    end
  end

  assign sts_o.op        = op_q;
  assign sts_o.empty     = empty;
  assign sts_o.full      = full;
  assign sts_o.walk_last = ((k_q + 1'b1) == count_q);
  assign sts_o.out_free  = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= sqe_pkg::CNT_W'(sqe_pkg::DEPTH))
    else $error("entry count beyond store depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push |-> !full) and (cmd_i.pop |-> !empty))
    else $error("store update against full or empty store");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> out_free)
    else $error("result register overwritten while held");

endmodule

`default_nettype wire

[design/stack_queue_engine_unit.sv]
// ----------------------------------------------------------------------------
// stack_queue_engine_unit
// Bounded store of signed 32-bit entries, switchable between stack and queue.
// ----------------------------------------------------------------------------
// One command beat is taken at a time. Set mode, push and pop are accepted,
// then executed against the head/count registers; peek adds a step for the
// registered read of the entry store. Dump of N entries reads them through
// the store's single read port into the result register, one entry per
// cycle while it is free; an empty dump gives no result beat. The
// result register lets the next command be accepted while a beat waits.
`default_nettype none

module stack_queue_engine_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sqe_in_if.sink     in_i,
  sqe_out_if.source  out_o
);

  sqe_pkg::sqe_cmd_t cmd;
  sqe_pkg::sqe_sts_t sts;

  sqe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sqe_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .operation_i  (in_i.operation),
    .push_data_i  (in_i.push_data),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_data_o   (out_o.data),
    .out_status_o (out_o.status),
    .out_last_o   (out_o.last),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

`default_nettype wire
